// ===== sv/ptpu_pkg.sv =====
// ----------------------------------------------------------------------------
// PNG/TIFF predictor undo: shared package
// Types, register indexes and default sizes used by the predictor undo block.
// ----------------------------------------------------------------------------
package ptpu_pkg;

  localparam int RowMaxDef = 4096;
  localparam int BppMaxDef = 8;

  localparam int ByteW    = 8;
  localparam int ModeW    = 2;
  localparam int BppW     = 4;
  localparam int RowW     = 13;
  localparam int CfgIdxW  = 2;
  localparam int CfgDataW = 13;

  // Tag values above this one all mean "repeat the byte above".
  localparam int TagRepeat = 6;

  typedef enum logic [ModeW-1:0] {
    MODE_NONE     = 2'd0,
    MODE_TIFF     = 2'd1,
    MODE_PNG      = 2'd2,
    MODE_TIFF_BAD = 2'd3
  } mode_e;

  typedef enum logic [CfgIdxW-1:0] {
    REG_MODE = 2'd0,
    REG_BPP  = 2'd1,
    REG_ROW  = 2'd2
  } reg_e;

  typedef enum logic [2:0] {
    FILT_NONE   = 3'd0,
    FILT_SUB    = 3'd1,
    FILT_UP     = 3'd2,
    FILT_AVG    = 3'd3,
    FILT_PAETH  = 3'd4,
    FILT_OPT    = 3'd5,
    FILT_REPEAT = 3'd6
  } filter_e;

  typedef enum logic [1:0] {
    STATUS_OK        = 2'd0,
    STATUS_TAG_ERR   = 2'd1,
    STATUS_WIDTH_ERR = 2'd2
  } status_e;

  typedef struct packed {
    logic [ByteW-1:0] data;
    logic             row_end;
    status_e          status;
  } result_t;

endpackage

// ===== sv/ptpu_row_store.sv =====
// ----------------------------------------------------------------------------
// PNG/TIFF predictor undo: row store
// Single-port-write memory holding the previous row, with a clearing sweep
// after reset and a registered read of the byte above the next column.
// ----------------------------------------------------------------------------
module ptpu_row_store #(
  parameter int ROW_MAX = ptpu_pkg::RowMaxDef,
  localparam int CW = $clog2(ROW_MAX)
) (
  input  logic                      clk_i,
  input  logic                      rst_ni,
  input  logic                      wr_en_i,
  input  logic [CW-1:0]             wr_addr_i,
  input  logic [ptpu_pkg::ByteW-1:0] wr_data_i,
  input  logic [CW-1:0]             rd_addr_i,
  output logic [ptpu_pkg::ByteW-1:0] up_o,
  output logic                      busy_o
);

  logic [ptpu_pkg::ByteW-1:0] mem [ROW_MAX];

  logic                       clr_q;
  logic [CW-1:0]              clr_addr_q;
  logic                       we;
  logic [CW-1:0]              waddr;
  logic [ptpu_pkg::ByteW-1:0] wdata;
  logic [ptpu_pkg::ByteW-1:0] rd_q;
  logic                       byp_q;
  logic [ptpu_pkg::ByteW-1:0] byp_data_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_q      <= 1'b1;
      clr_addr_q <= '0;
    end else if (clr_q) begin
      if (clr_addr_q == CW'(ROW_MAX - 1)) begin
        clr_q <= 1'b0;
      end
      clr_addr_q <= clr_addr_q + CW'(1);
    end
  end

  assign we    = clr_q | wr_en_i;
  assign waddr = clr_q ? clr_addr_q : wr_addr_i;
  assign wdata = clr_q ? '0 : wr_data_i;

  // The read always targets the column of the next item; when that column is
  // written in the same cycle the new byte is forwarded instead.
  always_ff @(posedge clk_i) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rd_q       <= mem[rd_addr_i];
    byp_q      <= we && (waddr == rd_addr_i);
    byp_data_q <= wdata;
  end

  assign up_o   = byp_q ? byp_data_q : rd_q;
  assign busy_o = clr_q;

endmodule

// ===== sv/ptpu_core.sv =====
// ----------------------------------------------------------------------------
// PNG/TIFF predictor undo: decode core
// Row state, tag handling, error latch, left neighbor history and the
// combinational predictor for one item.
// ----------------------------------------------------------------------------
module ptpu_core #(
  parameter int ROW_MAX = ptpu_pkg::RowMaxDef,
  parameter int BPP_MAX = ptpu_pkg::BppMaxDef,
  localparam int CW = $clog2(ROW_MAX)
) (
  input  logic                        clk_i,
  input  logic                        rst_ni,
  input  logic                        go_i,
  input  logic [ptpu_pkg::ByteW-1:0]  byte_i,
  input  ptpu_pkg::mode_e             mode_i,
  input  logic [ptpu_pkg::BppW-1:0]   bpp_i,
  input  logic [ptpu_pkg::RowW-1:0]   row_bytes_i,
  input  logic [ptpu_pkg::ByteW-1:0]  up_i,
  output ptpu_pkg::result_t           res_o,
  output logic                        res_valid_o,
  output logic                        wr_en_o,
  output logic [CW-1:0]               wr_addr_o,
  output logic [ptpu_pkg::ByteW-1:0]  wr_data_o,
  output logic [CW-1:0]               rd_addr_o
);

  localparam int BPW  = $clog2(BPP_MAX + 1);
  localparam int BIW  = (BPP_MAX > 1) ? $clog2(BPP_MAX) : 1;
  localparam int CMPW = ((CW > ptpu_pkg::RowW) ? CW : ptpu_pkg::RowW) + 1;

  logic [CW-1:0]             column_q, column_d;
  ptpu_pkg::filter_e         filt_q, filt_d;
  logic                      expect_q, expect_d;
  logic                      err_q, err_d;
  logic [ptpu_pkg::ByteW-1:0] hist_q [BPP_MAX];

  logic [BPW-1:0]            bpp_eff;
  logic [CMPW-1:0]           rb_eff;
  logic [ptpu_pkg::ByteW-1:0] left;
  logic [ptpu_pkg::ByteW:0]  avg_sum;
  logic [ptpu_pkg::ByteW-1:0] val;
  logic                      row_done;
  ptpu_pkg::filter_e         filter;
  ptpu_pkg::filter_e         tag_filter;

  // Register clamping: zero acts as one, large values act as the maximum.
  always_comb begin
    if (bpp_i == '0) begin
      bpp_eff = BPW'(1);
    end else if (5'(bpp_i) > 5'(BPP_MAX)) begin
      bpp_eff = BPW'(BPP_MAX);
    end else begin
      bpp_eff = BPW'(bpp_i);
    end
    if (row_bytes_i == '0) begin
      rb_eff = CMPW'(1);
    end else if (CMPW'(row_bytes_i) > CMPW'(ROW_MAX)) begin
      rb_eff = CMPW'(ROW_MAX);
    end else begin
      rb_eff = CMPW'(row_bytes_i);
    end
  end

  // The left neighbor is always a byte decoded earlier in this row, so a short
  // history of recent bytes replaces a second read of the row store.
  assign left = (CMPW'(column_q) >= CMPW'(bpp_eff)) ? hist_q[BIW'(bpp_eff - BPW'(1))] : '0;

  assign avg_sum    = {1'b0, left} + {1'b0, up_i};
  assign filter     = (mode_i == ptpu_pkg::MODE_TIFF) ? ptpu_pkg::FILT_SUB : filt_q;
  assign tag_filter = (byte_i > ptpu_pkg::ByteW'(ptpu_pkg::TagRepeat)) ?
                      ptpu_pkg::FILT_REPEAT : ptpu_pkg::filter_e'(byte_i[2:0]);
  assign row_done   = (CMPW'(column_q) + CMPW'(1)) >= rb_eff;

  always_comb begin
    unique case (filter)
      ptpu_pkg::FILT_NONE: val = byte_i;
      ptpu_pkg::FILT_SUB:  val = byte_i + left;
      ptpu_pkg::FILT_UP:   val = byte_i + up_i;
      ptpu_pkg::FILT_AVG:  val = byte_i + avg_sum[ptpu_pkg::ByteW:1];
      default:             val = up_i;
    endcase
  end

  always_comb begin
    column_d    = column_q;
    filt_d      = filt_q;
    expect_d    = expect_q;
    err_d       = err_q;
    res_o       = '{data: '0, row_end: 1'b0, status: ptpu_pkg::STATUS_OK};
    res_valid_o = 1'b0;
    wr_en_o     = 1'b0;
    if (go_i) begin
      priority if (err_q) begin
        res_valid_o = 1'b1;
        res_o.status = (mode_i == ptpu_pkg::MODE_TIFF_BAD) ?
                       ptpu_pkg::STATUS_WIDTH_ERR : ptpu_pkg::STATUS_TAG_ERR;
      end else if (mode_i == ptpu_pkg::MODE_NONE) begin
        res_valid_o = 1'b1;
        res_o.data  = byte_i;
      end else if (mode_i == ptpu_pkg::MODE_TIFF_BAD) begin
        err_d        = 1'b1;
        res_valid_o  = 1'b1;
        res_o.status = ptpu_pkg::STATUS_WIDTH_ERR;
      end else if (mode_i == ptpu_pkg::MODE_PNG && expect_q) begin
        filt_d   = tag_filter;
        expect_d = 1'b0;
      end else if (filter == ptpu_pkg::FILT_PAETH || filter == ptpu_pkg::FILT_OPT) begin
        err_d        = 1'b1;
        res_valid_o  = 1'b1;
        res_o.status = ptpu_pkg::STATUS_TAG_ERR;
      end else begin
        wr_en_o       = 1'b1;
        res_valid_o   = 1'b1;
        res_o.data    = val;
        res_o.row_end = row_done;
        if (row_done) begin
          column_d = '0;
          expect_d = 1'b1;
        end else begin
          column_d = column_q + CW'(1);
        end
      end
    end
  end

  assign wr_addr_o = column_q;
  assign wr_data_o = val;
  assign rd_addr_o = column_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      column_q <= '0;
      filt_q   <= ptpu_pkg::FILT_NONE;
      expect_q <= 1'b1;
      err_q    <= 1'b0;
    end else begin
      column_q <= column_d;
      filt_q   <= filt_d;
      expect_q <= expect_d;
      err_q    <= err_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_o) begin
      hist_q[0] <= val;
      for (int i = 1; i < BPP_MAX; i++) begin
        hist_q[i] <= hist_q[i-1];
      end
    end
  end

`ifndef NO_ASSERTIONS
  a_write_needs_item: assert property (@(posedge clk_i) disable iff (!rst_ni)
    wr_en_o |-> go_i && res_valid_o)
    else $error("row store written without an item");

  a_error_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    err_q |=> err_q)
    else $error("error latch cleared outside reset");

  a_column_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    CMPW'(column_q) < CMPW'(ROW_MAX))
    else $error("column index beyond the row store");

  a_row_end_ok: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o && res_o.row_end |-> res_o.status == ptpu_pkg::STATUS_OK && !err_q)
    else $error("row end marked on an error item");
`endif

endmodule

// ===== sv/png_tiff_predictor_undo.sv =====
// ----------------------------------------------------------------------------
// PNG/TIFF predictor undo
// Reverses the TIFF byte predictor and the PNG row filters on a byte stream.
//
//   channel   direction  handshake                  payload
//   in        input      in_valid_i / in_ready_o    in_byte_i
//   out       output     out_valid_o / out_ready_i  out_byte_o, row_end_o, status_o
//   cfg       input      cfg_we_i                   cfg_index_i, cfg_wdata_i
//
// One item per cycle is accepted while in_ready_o is high; a data byte is held
// in the input register, decoded once the result register is free, and
// out_valid_o rises when its result is registered. A PNG tag byte produces no
// output item. After reset the row store is swept to zero while in_ready_o
// stays low; configuration writes are taken during the sweep.
// A full result register with out_ready_i low holds a waiting item in the
// input register and drops in_ready_o.
// ----------------------------------------------------------------------------
module png_tiff_predictor_undo #(
  parameter int ROW_MAX = ptpu_pkg::RowMaxDef,
  parameter int BPP_MAX = ptpu_pkg::BppMaxDef
) (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          in_valid_i,
  output logic                          in_ready_o,
  input  logic [ptpu_pkg::ByteW-1:0]    in_byte_i,
  output logic                          out_valid_o,
  input  logic                          out_ready_i,
  output logic [ptpu_pkg::ByteW-1:0]    out_byte_o,
  output logic                          row_end_o,
  output logic [1:0]                    status_o,
  input  logic                          cfg_we_i,
  input  logic [ptpu_pkg::CfgIdxW-1:0]  cfg_index_i,
  input  logic [ptpu_pkg::CfgDataW-1:0] cfg_wdata_i
);

  localparam int CW = $clog2(ROW_MAX);

  ptpu_pkg::mode_e             mode_q;
  logic [ptpu_pkg::BppW-1:0]   bpp_q;
  logic [ptpu_pkg::RowW-1:0]   row_bytes_q;

  logic                        in_valid_q;
  logic [ptpu_pkg::ByteW-1:0]  in_byte_q;
  logic                        out_valid_q;
  ptpu_pkg::result_t           out_q;

  logic                        go;
  logic                        busy;
  ptpu_pkg::result_t           res;
  logic                        res_valid;
  logic                        wr_en;
  logic [CW-1:0]               wr_addr;
  logic [ptpu_pkg::ByteW-1:0]  wr_data;
  logic [CW-1:0]               rd_addr;
  logic [ptpu_pkg::ByteW-1:0]  up;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q      <= ptpu_pkg::MODE_NONE;
      bpp_q       <= ptpu_pkg::BppW'(1);
      row_bytes_q <= ptpu_pkg::RowW'(1);
    end else if (cfg_we_i) begin
      unique case (cfg_index_i)
        ptpu_pkg::REG_MODE: mode_q <= ptpu_pkg::mode_e'(cfg_wdata_i[ptpu_pkg::ModeW-1:0]);
        ptpu_pkg::REG_BPP:  bpp_q <= cfg_wdata_i[ptpu_pkg::BppW-1:0];
        ptpu_pkg::REG_ROW:  row_bytes_q <= cfg_wdata_i[ptpu_pkg::RowW-1:0];
        default: ;
      endcase
    end
  end

  // The held item moves on when the result register is free or being emptied.
  assign go         = in_valid_q && (!out_valid_q || out_ready_i);
  assign in_ready_o = !busy && (!in_valid_q || go);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      if (in_ready_o) begin
        in_valid_q <= in_valid_i;
      end
      if (go && res_valid) begin
        out_valid_q <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (in_ready_o && in_valid_i) begin
      in_byte_q <= in_byte_i;
    end
    if (go && res_valid) begin
      out_q <= res;
    end
  end

  ptpu_core #(
    .ROW_MAX (ROW_MAX),
    .BPP_MAX (BPP_MAX)
  ) u_core (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .go_i        (go),
    .byte_i      (in_byte_q),
    .mode_i      (mode_q),
    .bpp_i       (bpp_q),
    .row_bytes_i (row_bytes_q),
    .up_i        (up),
    .res_o       (res),
    .res_valid_o (res_valid),
    .wr_en_o     (wr_en),
    .wr_addr_o   (wr_addr),
    .wr_data_o   (wr_data),
    .rd_addr_o   (rd_addr)
  );

  ptpu_row_store #(
    .ROW_MAX (ROW_MAX)
  ) u_row_store (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .wr_en_i   (wr_en),
    .wr_addr_i (wr_addr),
    .wr_data_i (wr_data),
    .rd_addr_i (rd_addr),
    .up_o      (up),
    .busy_o    (busy)
  );

  assign out_valid_o = out_valid_q;
  assign out_byte_o  = out_q.data;
  assign row_end_o   = out_q.row_end;
  assign status_o    = out_q.status;

endmodule
